// File: rtl/soc_pkg.sv
// Shared types, constants and helper functions for the OCV state-of-charge lookup.
// Used by every module of the block except soc_ram; depends on nothing.
package soc_pkg;

    localparam int DSG_ROWS        = 32;
    localparam int CHG_ROWS        = 32;
    localparam int STATIC_ROWS     = 32;
    localparam int DSG_CUR_BANDS   = 7;
    localparam int DSG_TEMP_BANDS  = 4;
    localparam int CHG_TEMP_BANDS  = 3;

    localparam int DSG_DEPTH       = 1024;
    localparam int CHG_DEPTH       = 128;
    localparam int STA_DEPTH       = 64;
    localparam int THR_DEPTH       = 11;
    localparam int THR_CUR_BASE    = 0;
    localparam int THR_DT_BASE     = 6;
    localparam int THR_CT_BASE     = 9;

    localparam int ADC_W   = 12;
    localparam int WORD_W  = 16;
    localparam int ADDR_W  = 10;
    localparam int COL_W   = 3;
    localparam int ROW_W   = 8;
    localparam int IDX_W   = 9;
    localparam int THR_AW  = 4;
    localparam int SOC_W   = 8;
    localparam int CALC_W  = 16;

    localparam int DSG_STRIDE = DSG_CUR_BANDS + 1;
    localparam int CHG_STRIDE = CHG_TEMP_BANDS + 1;
    localparam int STA_STRIDE = 2;

    // cap / 100 as (cap * 5243) >> 19, exact for every cap below 43699
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;
    localparam int DIV100_MW    = 13;
    localparam int SOC_MAX      = 255;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_WRITE  = 1'b1;

    localparam logic [1:0] MODE_CHARGE = 2'd1;
    localparam logic [1:0] MODE_RELAX  = 2'd2;

    typedef enum logic [1:0] {
        SEL_DSG = 2'd0,
        SEL_CHG = 2'd1,
        SEL_STA = 2'd2,
        SEL_THR = 2'd3
    } sel_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_CAPRD,
        B_CAP
    } back_state_t;

    typedef struct packed {
        logic              is_write;
        sel_t              sel;
        logic [ADDR_W-1:0] addr;  // write address, or table base for a lookup
        logic [COL_W-1:0]  col;   // voltage column for a lookup
        logic [WORD_W-1:0] val;   // word to write, or millivolts for a lookup
    } entry_t;

    function automatic logic [IDX_W-1:0] rows_of(input sel_t sel);
        logic [IDX_W-1:0] r;
        unique case (sel)
            SEL_CHG: r = IDX_W'(CHG_ROWS);
            SEL_STA: r = IDX_W'(STATIC_ROWS);
            default: r = IDX_W'(DSG_ROWS);
        endcase
        return r;
    endfunction

    function automatic logic [3:0] stride_of(input sel_t sel);
        logic [3:0] s;
        unique case (sel)
            SEL_CHG: s = 4'(CHG_STRIDE);
            SEL_STA: s = 4'(STA_STRIDE);
            default: s = 4'(DSG_STRIDE);
        endcase
        return s;
    endfunction

    function automatic logic [COL_W-1:0] cap_col_of(input sel_t sel);
        logic [COL_W-1:0] c;
        unique case (sel)
            SEL_CHG: c = COL_W'(CHG_TEMP_BANDS);
            SEL_STA: c = COL_W'(1);
            default: c = COL_W'(DSG_CUR_BANDS);
        endcase
        return c;
    endfunction

endpackage

// File: rtl/battery_soc_ocv_table_lookup.sv
// Top level of the OCV state-of-charge lookup block.
// Depends on soc_pkg, soc_front, soc_queue, soc_back (and soc_ram through it).
//
// Usage. Items arrive on the input channel (in_valid / in_stall); a transfer
// takes place on a clock edge with in_valid high and in_stall low. A write
// item (cmd = 1) loads one word into the discharge, charge or static table
// or into the threshold store and gives no result. A lookup item (cmd = 0)
// gives one result transfer on the output channel (out_valid / out_stall)
// carrying soc_percent and raw_capacity. Results leave in item order.
// The scale register is written with cfg_we / cfg_data; the user must write
// it only while the block idles, which the block itself does not enforce.
// The scan reads the first row, the last row, then rows from the second
// onwards, so a 32-row table costs at most 33 reads through the single read
// port of the table memory. The back part starts a new lookup only once the
// last result has entered the result register. The front part takes no new
// item while its first stage is full (in_stall) and feeds a two-entry queue,
// so writes and lookups queue up while the back part scans. Reset clears all
// control state and loads the scale with 1.0 (4096); table and threshold
// contents are not cleared. When the receiver stalls, the result register
// holds, one further lookup completes, then the queue fills and raises in_stall.
module battery_soc_ocv_table_lookup (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [soc_pkg::WORD_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic [soc_pkg::ADC_W-1:0]     volt_sample,
    input  logic [soc_pkg::ADC_W-1:0]     curr_sample,
    input  logic [soc_pkg::ADC_W-1:0]     temp_sample,
    input  logic [1:0]                    current_mode,
    input  logic [1:0]                    table_select,
    input  logic [soc_pkg::ADDR_W-1:0]    table_address,
    input  logic [soc_pkg::WORD_W-1:0]    table_word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [soc_pkg::SOC_W-1:0]     soc_percent,
    output logic [soc_pkg::WORD_W-1:0]    raw_capacity
);

    logic            push, pop, q_full, q_empty;
    soc_pkg::entry_t push_entry, head;

    // Front: takes the transfer, scales the voltage and classifies the item.
    soc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cmd             (cmd),
        .volt_sample     (volt_sample),
        .curr_sample     (curr_sample),
        .temp_sample     (temp_sample),
        .current_mode    (current_mode),
        .table_select    (table_select),
        .table_address   (table_address),
        .table_word      (table_word),
        .push            (push),
        .push_entry      (push_entry),
        .q_full          (q_full)
    );

    soc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .empty      (q_empty),
        .head       (head)
    );

    // Back: table writes, the row scan and the result register.
    soc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (q_empty),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .soc_percent  (soc_percent),
        .raw_capacity (raw_capacity)
    );

endmodule

// File: rtl/soc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module soc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/soc_front.sv
// Front part: accepts items, holds the thresholds and scale register, scales
// the voltage and picks bands. Depends on soc_pkg.
module soc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [soc_pkg::WORD_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic [soc_pkg::ADC_W-1:0]     volt_sample,
    input  logic [soc_pkg::ADC_W-1:0]     curr_sample,
    input  logic [soc_pkg::ADC_W-1:0]     temp_sample,
    input  logic [1:0]                    current_mode,
    input  logic [1:0]                    table_select,
    input  logic [soc_pkg::ADDR_W-1:0]    table_address,
    input  logic [soc_pkg::WORD_W-1:0]    table_word,
    output logic                          push,
    output soc_pkg::entry_t               push_entry,
    input  logic                          q_full
);

    logic [soc_pkg::WORD_W-1:0] scale_reg;
    logic [soc_pkg::WORD_W-1:0] thr_reg [soc_pkg::THR_DEPTH];

    logic                        s1_valid_reg;
    logic                        s1_cmd_reg;
    logic [soc_pkg::ADC_W-1:0]   s1_av_reg, s1_ai_reg, s1_at_reg;
    logic [1:0]                  s1_mode_reg;
    soc_pkg::sel_t               s1_sel_reg;
    logic [soc_pkg::ADDR_W-1:0]  s1_addr_reg;
    logic [soc_pkg::WORD_W-1:0]  s1_word_reg;

    logic                        s2_valid_reg;
    logic                        s2_write_reg;
    logic [1:0]                  s2_mode_reg;
    soc_pkg::sel_t               s2_sel_reg;
    logic [soc_pkg::ADDR_W-1:0]  s2_addr_reg;
    logic [soc_pkg::WORD_W-1:0]  s2_word_reg;
    logic [soc_pkg::WORD_W-1:0]  s2_mv_reg;
    logic [2:0]                  s2_cb_reg;
    logic [1:0]                  s2_dtb_reg, s2_ctb_reg;

    logic                        accept, s1_move;
    logic [soc_pkg::ADC_W+soc_pkg::WORD_W-1:0] product;
    logic [2:0]                  cb;
    logic [1:0]                  dtb, ctb;

    assign in_stall = s1_valid_reg;
    assign accept   = in_valid && !s1_valid_reg;
    assign push     = s2_valid_reg && !q_full;
    assign s1_move  = s1_valid_reg && (!s2_valid_reg || push);

    // Band selection: first threshold that matches wins, else the last band.
    always_comb
    begin
        product = (soc_pkg::ADC_W+soc_pkg::WORD_W)'(s1_av_reg) *
                  (soc_pkg::ADC_W+soc_pkg::WORD_W)'(scale_reg);
        cb  = 3'(soc_pkg::DSG_CUR_BANDS - 1);
        dtb = 2'(soc_pkg::DSG_TEMP_BANDS - 1);
        ctb = 2'(soc_pkg::CHG_TEMP_BANDS - 1);
        for (int k = soc_pkg::DSG_CUR_BANDS - 2; k >= 0; k--)
        begin
            if (soc_pkg::WORD_W'(s1_ai_reg) <= thr_reg[soc_pkg::THR_CUR_BASE + k])
            begin
                cb = 3'(k);
            end
        end
        for (int k = soc_pkg::DSG_TEMP_BANDS - 2; k >= 0; k--)
        begin
            if (soc_pkg::WORD_W'(s1_at_reg) >= thr_reg[soc_pkg::THR_DT_BASE + k])
            begin
                dtb = 2'(k);
            end
        end
        for (int k = soc_pkg::CHG_TEMP_BANDS - 2; k >= 0; k--)
        begin
            if (soc_pkg::WORD_W'(s1_at_reg) >= thr_reg[soc_pkg::THR_CT_BASE + k])
            begin
                ctb = 2'(k);
            end
        end
    end

    always_comb
    begin
        push_entry.is_write = s2_write_reg;
        push_entry.sel      = s2_sel_reg;
        push_entry.addr     = s2_addr_reg;
        push_entry.col      = '0;
        push_entry.val      = s2_word_reg;
        if (!s2_write_reg)
        begin
            push_entry.val = s2_mv_reg;
            priority if (s2_mode_reg == soc_pkg::MODE_CHARGE)
            begin
                push_entry.sel  = soc_pkg::SEL_CHG;
                push_entry.addr = '0;
                push_entry.col  = soc_pkg::COL_W'(s2_ctb_reg);
            end
            else if (s2_mode_reg == soc_pkg::MODE_RELAX)
            begin
                push_entry.sel  = soc_pkg::SEL_STA;
                push_entry.addr = '0;
            end
            else
            begin
                push_entry.sel  = soc_pkg::SEL_DSG;
                push_entry.addr = soc_pkg::ADDR_W'(soc_pkg::CALC_W'(s2_dtb_reg) *
                    soc_pkg::CALC_W'(soc_pkg::DSG_ROWS * soc_pkg::DSG_STRIDE));
                push_entry.col  = s2_cb_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg    <= soc_pkg::WORD_W'(4096);
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                scale_reg <= cfg_data;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                // threshold writes end here; table writes and lookups go on
                s2_valid_reg <= !(s1_cmd_reg == soc_pkg::CMD_WRITE &&
                                  s1_sel_reg == soc_pkg::SEL_THR);
            end
            else if (push)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg  <= cmd;
            s1_av_reg   <= volt_sample;
            s1_ai_reg   <= curr_sample;
            s1_at_reg   <= temp_sample;
            s1_mode_reg <= current_mode;
            s1_sel_reg  <= soc_pkg::sel_t'(table_select);
            s1_addr_reg <= table_address;
            s1_word_reg <= table_word;
            if (cmd == soc_pkg::CMD_WRITE &&
                soc_pkg::sel_t'(table_select) == soc_pkg::SEL_THR &&
                table_address < soc_pkg::ADDR_W'(soc_pkg::THR_DEPTH))
            begin
                thr_reg[table_address[soc_pkg::THR_AW-1:0]] <= table_word;
            end
        end
        if (s1_move)
        begin
            s2_write_reg <= (s1_cmd_reg == soc_pkg::CMD_WRITE);
            s2_mode_reg  <= s1_mode_reg;
            s2_sel_reg   <= s1_sel_reg;
            s2_addr_reg  <= s1_addr_reg;
            s2_word_reg  <= s1_word_reg;
            s2_mv_reg    <= product[soc_pkg::ADC_W+soc_pkg::WORD_W-1:12];
            s2_cb_reg    <= cb;
            s2_dtb_reg   <= dtb;
            s2_ctb_reg   <= ctb;
        end
    end

endmodule

// File: rtl/soc_queue.sv
// Two-entry queue between the front and back parts.
// Depends on soc_pkg for the entry type.
module soc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  soc_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output soc_pkg::entry_t head
);

    soc_pkg::entry_t slot_reg [2];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [1:0]      count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: rtl/soc_back.sv
// Back part: table memories, row scan sequencer and the result register.
// Depends on soc_pkg and soc_ram.
module soc_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        empty,
    input  soc_pkg::entry_t             head,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [soc_pkg::SOC_W-1:0]   soc_percent,
    output logic [soc_pkg::WORD_W-1:0]  raw_capacity
);

    soc_pkg::back_state_t state_reg, state_next;
    soc_pkg::entry_t      job_reg;
    logic [soc_pkg::IDX_W-1:0] idx_reg, chk_idx_reg;
    logic                 chk_valid_reg;
    logic [soc_pkg::ROW_W-1:0] hit_row_reg;
    logic [soc_pkg::WORD_W-1:0] cap_reg;
    logic                 cap_ready_reg;
    logic                 out_valid_reg;
    logic [soc_pkg::SOC_W-1:0]  soc_reg;
    logic [soc_pkg::WORD_W-1:0] raw_reg;

    logic                 we_dsg, we_chg, we_sta;
    logic [soc_pkg::ADDR_W-1:0] raddr;
    logic [soc_pkg::WORD_W-1:0] rd_dsg, rd_chg, rd_sta, rdata;
    logic [soc_pkg::IDX_W-1:0]  rows;
    logic                 issue, hit, out_load;
    logic [soc_pkg::ROW_W-1:0]  issue_row, chk_row;
    logic [soc_pkg::CALC_W+soc_pkg::DIV100_MW-1:0] quot_prod;
    logic [soc_pkg::WORD_W-1:0] quot;

    function automatic logic [soc_pkg::ROW_W-1:0] row_of(
        input logic [soc_pkg::IDX_W-1:0] idx,
        input logic [soc_pkg::IDX_W-1:0] nrows);
        logic [soc_pkg::IDX_W-1:0] r;
        // order: first row, last row, then rows from the second onwards
        priority if (idx == '0)
            r = '0;
        else if (idx == soc_pkg::IDX_W'(1))
            r = nrows - soc_pkg::IDX_W'(1);
        else
            r = idx - soc_pkg::IDX_W'(1);
        return r[soc_pkg::ROW_W-1:0];
    endfunction

    function automatic logic [soc_pkg::ADDR_W-1:0] addr_of(
        input soc_pkg::entry_t e,
        input logic [soc_pkg::ROW_W-1:0] row,
        input logic [soc_pkg::COL_W-1:0] col);
        logic [soc_pkg::CALC_W-1:0] a;
        a = soc_pkg::CALC_W'(e.addr) +
            soc_pkg::CALC_W'(row) * soc_pkg::CALC_W'(soc_pkg::stride_of(e.sel)) +
            soc_pkg::CALC_W'(col);
        return a[soc_pkg::ADDR_W-1:0];
    endfunction

    assign rows      = soc_pkg::rows_of(job_reg.sel);
    assign issue_row = row_of(idx_reg, rows);
    assign chk_row   = row_of(chk_idx_reg, rows);

    always_comb
    begin
        unique case (job_reg.sel)
            soc_pkg::SEL_CHG: rdata = rd_chg;
            soc_pkg::SEL_STA: rdata = rd_sta;
            default:          rdata = rd_dsg;
        endcase
    end

    // Row match: last row checks "at or below", the others "at or above"; the final read always matches.
    always_comb
    begin
        if (chk_idx_reg == soc_pkg::IDX_W'(1))
            hit = job_reg.val <= rdata;
        else
            hit = (job_reg.val >= rdata) || (chk_idx_reg == rows);
    end

    assign out_load  = cap_ready_reg && (!out_valid_reg || !out_stall);
    assign quot_prod = (soc_pkg::CALC_W+soc_pkg::DIV100_MW)'(cap_reg) *
                       (soc_pkg::CALC_W+soc_pkg::DIV100_MW)'(soc_pkg::DIV100_MUL);
    assign quot      = soc_pkg::WORD_W'(quot_prod >> soc_pkg::DIV100_SHIFT);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            soc_pkg::B_IDLE:
                if (!empty && !head.is_write && !cap_ready_reg)
                    state_next = soc_pkg::B_SCAN;
            soc_pkg::B_SCAN:
                if (chk_valid_reg && hit)
                    state_next = soc_pkg::B_CAPRD;
            soc_pkg::B_CAPRD:
                state_next = soc_pkg::B_CAP;
            soc_pkg::B_CAP:
                state_next = soc_pkg::B_IDLE;
            default:
                state_next = soc_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        pop    = 1'b0;
        issue  = 1'b0;
        we_dsg = 1'b0;
        we_chg = 1'b0;
        we_sta = 1'b0;
        raddr  = addr_of(job_reg, issue_row, job_reg.col);
        unique case (state_reg)
            soc_pkg::B_IDLE:
            begin
                pop = !empty && (head.is_write || !cap_ready_reg);
                if (!empty && head.is_write)
                begin
                    we_dsg = head.sel == soc_pkg::SEL_DSG &&
                             (soc_pkg::ADDR_W+1)'(head.addr) <
                             (soc_pkg::ADDR_W+1)'(soc_pkg::DSG_DEPTH);
                    we_chg = head.sel == soc_pkg::SEL_CHG &&
                             head.addr < soc_pkg::ADDR_W'(soc_pkg::CHG_DEPTH);
                    we_sta = head.sel == soc_pkg::SEL_STA &&
                             head.addr < soc_pkg::ADDR_W'(soc_pkg::STA_DEPTH);
                end
            end
            soc_pkg::B_SCAN:
                issue = !(chk_valid_reg && hit) && idx_reg <= rows;
            soc_pkg::B_CAPRD:
                raddr = addr_of(job_reg, hit_row_reg, soc_pkg::cap_col_of(job_reg.sel));
            default:
                pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= soc_pkg::B_IDLE;
            chk_valid_reg <= 1'b0;
            cap_ready_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_valid_reg <= issue;
            if (state_reg == soc_pkg::B_CAP)
                cap_ready_reg <= 1'b1;
            else if (out_load)
                cap_ready_reg <= 1'b0;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == soc_pkg::B_IDLE && pop)
        begin
            job_reg <= head;
            idx_reg <= '0;
        end
        if (issue)
        begin
            idx_reg     <= idx_reg + soc_pkg::IDX_W'(1);
            chk_idx_reg <= idx_reg;
        end
        if (state_reg == soc_pkg::B_SCAN && chk_valid_reg && hit)
            hit_row_reg <= chk_row;
        if (state_reg == soc_pkg::B_CAP)
            cap_reg <= rdata;
        if (out_load)
        begin
            raw_reg <= cap_reg;
            soc_reg <= (quot > soc_pkg::WORD_W'(soc_pkg::SOC_MAX)) ?
                       soc_pkg::SOC_W'(soc_pkg::SOC_MAX) : quot[soc_pkg::SOC_W-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign soc_percent  = soc_reg;
    assign raw_capacity = raw_reg;

    soc_ram #(.WIDTH(soc_pkg::WORD_W), .DEPTH(soc_pkg::DSG_DEPTH)) u_dsg_ram (
        .clk   (clk),
        .we    (we_dsg),
        .waddr (head.addr[$clog2(soc_pkg::DSG_DEPTH)-1:0]),
        .wdata (head.val),
        .raddr (raddr[$clog2(soc_pkg::DSG_DEPTH)-1:0]),
        .rdata (rd_dsg)
    );

    soc_ram #(.WIDTH(soc_pkg::WORD_W), .DEPTH(soc_pkg::CHG_DEPTH)) u_chg_ram (
        .clk   (clk),
        .we    (we_chg),
        .waddr (head.addr[$clog2(soc_pkg::CHG_DEPTH)-1:0]),
        .wdata (head.val),
        .raddr (raddr[$clog2(soc_pkg::CHG_DEPTH)-1:0]),
        .rdata (rd_chg)
    );

    soc_ram #(.WIDTH(soc_pkg::WORD_W), .DEPTH(soc_pkg::STA_DEPTH)) u_sta_ram (
        .clk   (clk),
        .we    (we_sta),
        .waddr (head.addr[$clog2(soc_pkg::STA_DEPTH)-1:0]),
        .wdata (head.val),
        .raddr (raddr[$clog2(soc_pkg::STA_DEPTH)-1:0]),
        .rdata (rd_sta)
    );

endmodule
